// ===== hdl/tgsi_pkg.sv =====
`default_nettype none

package tgsi_pkg;

    localparam logic [7:0] MAX_FACES_PER_SIDE = 8'd254;
    localparam logic [7:0] FACES_RESET = 8'd64;
    localparam logic GAP_RESET = 1'b0;

    localparam logic CFG_FACES_PER_SIDE = 1'b0;
    localparam logic CFG_GAP_MODE = 1'b1;

    localparam logic [2:0] LAST_SLOT = 3'd7;

    localparam logic [1:0] OFF_ZERO = 2'd0;
    localparam logic [1:0] OFF_ONE = 2'd1;
    localparam logic [1:0] OFF_TWO = 2'd2;

    typedef struct packed {
        logic [6:0] block_row;
        logic [6:0] block_col;
    } item_t;

    typedef struct packed {
        logic [15:0] vertex_a;
        logic [15:0] vertex_b;
        logic [15:0] vertex_c;
        logic        is_padding;
        logic        range_error;
        logic        last_triangle;
    } result_t;

    // One classified block as it waits between the front and the back.
    typedef struct packed {
        logic [15:0] base;
        logic        top;
        logic        left;
        logic        last;
        logic        bad;
    } task_t;

    typedef struct packed {
        logic [1:0] dr;
        logic [1:0] dc;
    } vert_off_t;

    typedef struct packed {
        logic      pad;
        vert_off_t a;
        vert_off_t b;
        vert_off_t c;
    } tri_desc_t;

    function automatic tri_desc_t mk_tri(
        input logic [1:0] ar, input logic [1:0] ac,
        input logic [1:0] br, input logic [1:0] bc,
        input logic [1:0] cr, input logic [1:0] cc);
        tri_desc_t t;
        t.pad  = 1'b0;
        t.a.dr = ar;
        t.a.dc = ac;
        t.b.dr = br;
        t.b.dc = bc;
        t.c.dr = cr;
        t.c.dc = cc;
        return t;
    endfunction

    // Triangle in a given output slot of a block, with vertices relative to the
    // block's top-left vertex. Quads are visited top-left, top-right,
    // bottom-left, bottom-right, and the unused slots are fillers.
    function automatic tri_desc_t tri_lookup(
        input logic top, input logic left, input logic last, input logic [2:0] slot);
        tri_desc_t   list [8];
        tri_desc_t   filler;
        logic [3:0]  n;
        filler = '0;
        filler.pad = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            list[i] = filler;
        end
        n = 4'd0;
        if (left)
        begin
            list[n[2:0]] = mk_tri(OFF_ZERO, OFF_ZERO, OFF_TWO, OFF_ZERO, OFF_ONE, OFF_ONE);
            n = n + 4'd1;
            if (top)
            begin
                list[n[2:0]] = mk_tri(OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_TWO, OFF_ONE, OFF_ONE);
            end
            else
            begin
                list[n[2:0]] = mk_tri(OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_ONE, OFF_ONE, OFF_ONE);
            end
            n = n + 4'd1;
        end
        else if (top)
        begin
            list[n[2:0]] = mk_tri(OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_TWO, OFF_ONE, OFF_ONE);
            n = n + 4'd1;
            list[n[2:0]] = mk_tri(OFF_ZERO, OFF_ZERO, OFF_ONE, OFF_ZERO, OFF_ONE, OFF_ONE);
            n = n + 4'd1;
        end
        else
        begin
            list[n[2:0]] = mk_tri(OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_ONE, OFF_ONE, OFF_ZERO);
            n = n + 4'd1;
            list[n[2:0]] = mk_tri(OFF_ZERO, OFF_ONE, OFF_ONE, OFF_ZERO, OFF_ONE, OFF_ONE);
            n = n + 4'd1;
        end
        if (top)
        begin
            list[n[2:0]] = mk_tri(OFF_ZERO, OFF_TWO, OFF_ONE, OFF_ONE, OFF_ONE, OFF_TWO);
            n = n + 4'd1;
        end
        else
        begin
            list[n[2:0]] = mk_tri(OFF_ZERO, OFF_ONE, OFF_ZERO, OFF_TWO, OFF_ONE, OFF_ONE);
            n = n + 4'd1;
            list[n[2:0]] = mk_tri(OFF_ZERO, OFF_TWO, OFF_ONE, OFF_ONE, OFF_ONE, OFF_TWO);
            n = n + 4'd1;
        end
        if (left)
        begin
            list[n[2:0]] = mk_tri(OFF_ONE, OFF_ONE, OFF_TWO, OFF_ZERO, OFF_TWO, OFF_ONE);
            n = n + 4'd1;
        end
        else
        begin
            list[n[2:0]] = mk_tri(OFF_ONE, OFF_ZERO, OFF_ONE, OFF_ONE, OFF_TWO, OFF_ZERO);
            n = n + 4'd1;
            list[n[2:0]] = mk_tri(OFF_ONE, OFF_ONE, OFF_TWO, OFF_ZERO, OFF_TWO, OFF_ONE);
            n = n + 4'd1;
        end
        if (!last)
        begin
            list[n[2:0]] = mk_tri(OFF_ONE, OFF_ONE, OFF_ONE, OFF_TWO, OFF_TWO, OFF_ONE);
            n = n + 4'd1;
            list[n[2:0]] = mk_tri(OFF_ONE, OFF_TWO, OFF_TWO, OFF_ONE, OFF_TWO, OFF_TWO);
        end
        return list[slot];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/terrain_grid_stitch_index_gen_core.sv =====
`default_nettype none

// Index generator for a square terrain grid whose top row and left column are
// stitched to a coarser neighbor. Each block transfer on the input queue
// yields exactly eight triangle transfers on the result queue, one per cycle
// while pop keeps the result register free, so blocks stream back to back
// through the single result port. A block is stored in the queue, and its first
// triangle then in the result register, before that triangle is visible. The
// front classifies a block and computes its base vertex index in the cycle it
// is taken, and a small queue of QUEUE_DEPTH blocks decouples it from the
// triangle sequencer. Write the configuration registers only while no block
// is in flight.
module terrain_grid_stitch_index_gen_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic             cfg_index,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             push,
    output logic                  full,
    input  var tgsi_pkg::item_t   item,
    output logic                  empty,
    input  wire logic             pop,
    output var tgsi_pkg::result_t result
);

    logic [7:0]      faces_reg;
    logic [7:0]      faces_next;
    logic            gap_reg;
    logic            gap_next;
    tgsi_pkg::task_t front_blk;
    tgsi_pkg::task_t head;
    logic [7:0]      stride;
    logic            q_empty;
    logic            head_pop;

    always_comb
    begin
        faces_next = faces_reg;
        gap_next = gap_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                tgsi_pkg::CFG_FACES_PER_SIDE: faces_next = cfg_data;
                tgsi_pkg::CFG_GAP_MODE:       gap_next = cfg_data[0];
                default:                      faces_next = faces_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            faces_reg <= tgsi_pkg::FACES_RESET;
            gap_reg <= tgsi_pkg::GAP_RESET;
        end
        else
        begin
            faces_reg <= faces_next;
            gap_reg <= gap_next;
        end
    end

    tgsi_front u_front (
        .item           (item),
        .faces_per_side (faces_reg),
        .gap_mode       (gap_reg),
        .blk            (front_blk),
        .stride         (stride)
    );

    tgsi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (front_blk),
        .full     (full),
        .pop      (head_pop),
        .data_out (head),
        .empty    (q_empty)
    );

    tgsi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_empty),
        .head_pop   (head_pop),
        .stride     (stride),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

`ifndef NO_ASSERTIONS
    a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && empty) |=> !empty)
        else $error("queued block did not reach the result register");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.is_padding) |->
        (result.vertex_a == 16'd0 && result.vertex_b == 16'd0 && result.vertex_c == 16'd0))
        else $error("filler triangle carries nonzero vertices");

    a_err_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.range_error) |-> result.is_padding)
        else $error("rejected block produced a real triangle");
`endif

endmodule

`default_nettype wire

// ===== hdl/tgsi_front.sv =====
`default_nettype none

module tgsi_front (
    input  var tgsi_pkg::item_t item,
    input  wire logic [7:0]     faces_per_side,
    input  wire logic           gap_mode,
    output var tgsi_pkg::task_t blk,
    output logic [7:0]          stride
);

    logic [7:0]  f_sat;
    logic [7:0]  f_eff;
    logic [6:0]  half;
    logic [6:0]  half_m1;
    logic [7:0]  r0;
    logic [7:0]  c0;
    logic [15:0] prod;
    logic        corner;

    always_comb
    begin
        f_sat = (faces_per_side > tgsi_pkg::MAX_FACES_PER_SIDE)
              ? tgsi_pkg::MAX_FACES_PER_SIDE : faces_per_side;
        f_eff = {f_sat[7:1], 1'b0};
        half = f_eff[7:1];
        half_m1 = half - 7'd1;
        stride = f_eff + 8'd1;
        r0 = {item.block_row, 1'b0};
        c0 = {item.block_col, 1'b0};
        prod = {8'd0, r0} * {8'd0, stride};
        corner = (item.block_row == 7'd0) && (item.block_col == 7'd0);
        blk.base = prod + {8'd0, c0};
        blk.top = (item.block_row == 7'd0);
        blk.left = (item.block_col == 7'd0);
        blk.last = gap_mode && !corner
                 && (item.block_row == half_m1) && (item.block_col == half_m1);
        blk.bad = (item.block_row >= half) || (item.block_col >= half);
    end

endmodule

`default_nettype wire

// ===== hdl/tgsi_queue.sv =====
`default_nettype none

module tgsi_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  var tgsi_pkg::task_t data_in,
    output logic                full,
    input  wire logic           pop,
    output var tgsi_pkg::task_t data_out,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tgsi_pkg::task_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign data_out = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tgsi_back.sv =====
`default_nettype none

module tgsi_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  var tgsi_pkg::task_t   head,
    input  wire logic             head_valid,
    output logic                  head_pop,
    input  wire logic [7:0]       stride,
    output var tgsi_pkg::result_t result,
    output logic                  empty,
    input  wire logic             pop
);

    tgsi_pkg::result_t   out_reg;
    tgsi_pkg::result_t   out_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [2:0]          slot_reg;
    logic [2:0]          slot_next;
    logic                load;
    tgsi_pkg::tri_desc_t desc;

    function automatic logic [15:0] vert(
        input logic [15:0] base, input logic [7:0] s, input tgsi_pkg::vert_off_t o);
        logic [15:0] row_off;
        unique case (o.dr)
            tgsi_pkg::OFF_ONE: row_off = {8'd0, s};
            tgsi_pkg::OFF_TWO: row_off = {7'd0, s, 1'b0};
            default:           row_off = 16'd0;
        endcase
        return base + row_off + {14'd0, o.dc};
    endfunction

    assign load = head_valid && (!out_valid_reg || pop);
    assign head_pop = load && (slot_reg == tgsi_pkg::LAST_SLOT);
    assign desc = tgsi_pkg::tri_lookup(head.top, head.left, head.last, slot_reg);
    assign result = out_reg;
    assign empty = !out_valid_reg;

    always_comb
    begin
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        slot_next = slot_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            slot_next = slot_reg + 3'd1;
            out_next.last_triangle = (slot_reg == tgsi_pkg::LAST_SLOT);
            out_next.range_error = head.bad;
            if (head.bad || desc.pad)
            begin
                out_next.vertex_a = 16'd0;
                out_next.vertex_b = 16'd0;
                out_next.vertex_c = 16'd0;
                out_next.is_padding = 1'b1;
            end
            else
            begin
                out_next.vertex_a = vert(head.base, stride, desc.a);
                out_next.vertex_b = vert(head.base, stride, desc.b);
                out_next.vertex_c = vert(head.base, stride, desc.c);
                out_next.is_padding = 1'b0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire
